// ===== rtl/core/bmec_pkg.sv =====
// Package for the button mode entry controller: mode and event codes,
// item and result types, and the mode encoding. No dependencies.
package bmec_pkg;

  // Width of the wrapping tick arithmetic (16 to 32)
  localparam int unsigned TickBits = 32;

  localparam int unsigned NodeW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CodeW  = 3;

  // Configuration register indexes
  localparam logic CfgHoldTicks     = 1'b0;
  localparam logic CfgDebounceTicks = 1'b1;

  localparam logic [CfgW-1:0] HoldReset     = 16'd4000;
  localparam logic [CfgW-1:0] DebounceReset = 16'd250;

  typedef logic [TickBits-1:0] tick_t;

  // Event kinds
  typedef enum logic [2:0] {
    KindButton  = 3'd0,
    KindAssign  = 3'd1,
    KindLearnOn = 3'd2,
    KindLearnOff = 3'd3,
    KindRestore = 3'd4
  } kind_e;

  // Mode state, one-hot
  typedef enum logic [6:0] {
    ModeSimple       = 7'b0000001,
    ModeManaged      = 7'b0000010,
    ModePressed      = 7'b0000100,
    ModeFlashing     = 7'b0001000,
    ModeSetup        = 7'b0010000,
    ModePressedSetup = 7'b0100000,
    ModeLearn        = 7'b1000000
  } mode_e;

  // Mode codes as reported on the result
  localparam logic [CodeW-1:0] CodeSimple       = 3'd0;
  localparam logic [CodeW-1:0] CodeManaged      = 3'd1;
  localparam logic [CodeW-1:0] CodePressed      = 3'd2;
  localparam logic [CodeW-1:0] CodeFlashing     = 3'd3;
  localparam logic [CodeW-1:0] CodeSetup        = 3'd4;
  localparam logic [CodeW-1:0] CodePressedSetup = 3'd5;
  localparam logic [CodeW-1:0] CodeLearn        = 3'd6;

  typedef struct packed {
    logic [2:0]       kind;
    logic             button_down;
    logic [31:0]      now_tick;
    logic [NodeW-1:0] new_node;
    logic             stored_managed;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] mode;
    logic             request_node;
    logic             release_node;
    logic             start_flash;
    logic             save_details;
    logic             led_update;
    logic             led_managed;
    logic [NodeW-1:0] node_out;
  } res_t;

  // One-hot mode to reported code
  function automatic logic [CodeW-1:0] mode_code(mode_e m);
    logic [CodeW-1:0] c;
    case (m)
      ModeSimple:       c = CodeSimple;
      ModeManaged:      c = CodeManaged;
      ModePressed:      c = CodePressed;
      ModeFlashing:     c = CodeFlashing;
      ModeSetup:        c = CodeSetup;
      ModePressedSetup: c = CodePressedSetup;
      ModeLearn:        c = CodeLearn;
      default:          c = CodeSimple;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/bmec_in_reg.sv =====
// Input register stage of the button mode entry controller.
// Depends on bmec_pkg for the item type.
module bmec_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bmec_pkg::item_t item_i,
  input  logic            take_i,
  output logic            fire_o,
  output bmec_pkg::item_t item_o
);
  import bmec_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Item moves on when the result stage can take it
  assign fire_o     = valid_q & take_i;
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/bmec_step.sv =====
// Mode machine, node number, press timestamp and configuration registers.
// Depends on bmec_pkg. Produces the result of the item in the input register.
module bmec_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bmec_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        fire_i,
  input  bmec_pkg::item_t             item_i,
  output bmec_pkg::res_t              res_o
);
  import bmec_pkg::*;

  mode_e            mode_q, mode_d;
  mode_e            prior_q, prior_d;
  tick_t            press_q, press_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [CfgW-1:0]  hold_q, debounce_q;

  tick_t now;
  tick_t elapsed;
  logic  hold_hit, bounce_hit;
  logic  req, rel, flash, save, led_upd, led_val;

  // Wrapping elapsed time since the last press
  assign now        = tick_t'(item_i.now_tick);
  assign elapsed    = now - press_q;
  assign hold_hit   = elapsed > tick_t'(hold_q);
  assign bounce_hit = elapsed > tick_t'(debounce_q);

  // Next state and action flags
  always_comb begin
    mode_d  = mode_q;
    prior_d = prior_q;
    press_d = press_q;
    node_d  = node_q;
    req     = 1'b0;
    rel     = 1'b0;
    flash   = 1'b0;
    save    = 1'b0;
    led_upd = 1'b0;
    led_val = 1'b0;
    case (kind_e'(item_i.kind))
      KindButton: begin
        case (mode_q)
          ModeSimple, ModeManaged: begin
            if (item_i.button_down) begin
              prior_d = mode_q;
              mode_d  = ModePressed;
              press_d = now;
            end
          end
          ModePressed: begin
            if (item_i.button_down) begin
              if (hold_hit) begin
                mode_d = ModeFlashing;
                flash  = 1'b1;
              end
            end else if (prior_q == ModeManaged && bounce_hit) begin
              // short press on a managed node
              mode_d = ModeSetup;
              flash  = 1'b1;
              req    = 1'b1;
            end else begin
              mode_d = prior_q;
            end
          end
          ModeFlashing: begin
            if (!item_i.button_down) begin
              if (prior_q == ModeSimple) begin
                mode_d = ModeSetup;
                req    = 1'b1;
              end else begin
                // managed node gives its number back
                mode_d  = ModeSimple;
                rel     = 1'b1;
                led_upd = 1'b1;
                node_d  = '0;
                save    = 1'b1;
              end
            end
          end
          ModeSetup: begin
            if (item_i.button_down) begin
              mode_d  = ModePressedSetup;
              press_d = now;
            end
          end
          ModePressedSetup: begin
            if (!item_i.button_down) begin
              if (bounce_hit) begin
                mode_d  = prior_q;
                led_upd = 1'b1;
                led_val = (prior_q == ModeManaged);
              end else begin
                mode_d = ModeSetup;
              end
            end
          end
          default: begin
          end
        endcase
      end
      KindAssign: begin
        if (mode_q == ModeSetup) begin
          node_d  = item_i.new_node;
          mode_d  = ModeManaged;
          save    = 1'b1;
          led_upd = 1'b1;
          led_val = 1'b1;
        end
      end
      KindLearnOn: begin
        if (mode_q == ModeManaged) begin
          mode_d = ModeLearn;
        end
      end
      KindLearnOff: begin
        if (mode_q == ModeLearn) begin
          mode_d = ModeManaged;
        end
      end
      KindRestore: begin
        mode_d  = item_i.stored_managed ? ModeManaged : ModeSimple;
        prior_d = item_i.stored_managed ? ModeManaged : ModeSimple;
        node_d  = item_i.new_node;
        led_upd = 1'b1;
        led_val = item_i.stored_managed;
      end
      default: begin
      end
    endcase
  end

  // Result of this item, reflecting the updated state
  always_comb begin
    res_o.mode         = mode_code(mode_d);
    res_o.request_node = req;
    res_o.release_node = rel;
    res_o.start_flash  = flash;
    res_o.save_details = save;
    res_o.led_update   = led_upd;
    res_o.led_managed  = led_val;
    res_o.node_out     = node_d;
  end

  // State registers, updated once per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeSimple;
      prior_q <= ModeSimple;
      press_q <= '0;
      node_q  <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      prior_q <= prior_d;
      press_q <= press_d;
      node_q  <= node_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= HoldReset;
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgHoldTicks) begin
        hold_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgDebounceTicks) begin
        debounce_q <= cfg_data_i;
      end
    end
  end

  // Prior mode only ever records a settled mode
  a_prior_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prior_q == ModeSimple || prior_q == ModeManaged)
    else $error("prior mode is neither simple nor managed");

  // State holds when no item moves
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(mode_q) && $stable(node_q) && $stable(press_q))
    else $error("state changed without a transfer");

  // Release reverts to simple with node cleared
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rel |=> mode_q == ModeSimple && node_q == '0)
    else $error("release did not revert to simple");

  // Assignment in setup makes the node managed
  a_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.kind == KindAssign && mode_q == ModeSetup
    |=> mode_q == ModeManaged)
    else $error("assignment in setup not taken");

  // LED value only accompanies an LED update
  a_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_val |-> led_upd)
    else $error("LED value without update");

endmodule

// ===== rtl/core/bmec_out_reg.sv =====
// Result register stage of the button mode entry controller.
// Depends on bmec_pkg for the result type.
module bmec_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bmec_pkg::res_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bmec_pkg::res_t res_o
);
  import bmec_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Free when empty or when the held result transfers now
  assign ready_o     = ~valid_q | ~out_stall_i;
  assign valid_d     = fire_i | (valid_q & out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/core/button_mode_entry_controller.sv =====
// Button mode entry controller, top level: input register, mode step logic
// and result register. Depends on bmec_pkg, bmec_in_reg, bmec_step, bmec_out_reg.
//
// Steps a node's operating mode (simple, managed, pressed, flashing, setup,
// pressed in setup, learn) from button samples, node number assignment, learn
// enter/leave and restore events, and returns one result per event: action
// flags, the current mode code and the node number. The block takes one event
// per clock cycle while in_stall_o is low; each event passes through the input
// register, where the mode update logic computes its result, and then into the
// result register, which holds the result until it transfers. Button hold and
// debounce times are wrapping tick differences compared strictly greater than
// hold_ticks and debounce_ticks. Configuration writes take effect on the next
// cycle; no clearing after reset.
module button_mode_entry_controller (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bmec_pkg::CfgW-1:0] cfg_data_i,
  // events
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                kind_i,
  input  logic                      button_down_i,
  input  logic [31:0]               now_tick_i,
  input  logic [bmec_pkg::NodeW-1:0] new_node_i,
  input  logic                      stored_managed_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bmec_pkg::CodeW-1:0] mode_o,
  output logic                      request_node_o,
  output logic                      release_node_o,
  output logic                      start_flash_o,
  output logic                      save_details_o,
  output logic                      led_update_o,
  output logic                      led_managed_o,
  output logic [bmec_pkg::NodeW-1:0] node_out_o
);
  import bmec_pkg::*;

  item_t item_in, item_q;
  res_t  res_d, res_q;
  logic  take, fire;

  assign item_in.kind           = kind_i;
  assign item_in.button_down    = button_down_i;
  assign item_in.now_tick       = now_tick_i;
  assign item_in.new_node       = new_node_i;
  assign item_in.stored_managed = stored_managed_i;

  bmec_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (take),
    .fire_o     (fire),
    .item_o     (item_q)
  );

  bmec_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .res_o      (res_d)
  );

  bmec_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res_d),
    .ready_o     (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign mode_o         = res_q.mode;
  assign request_node_o = res_q.request_node;
  assign release_node_o = res_q.release_node;
  assign start_flash_o  = res_q.start_flash;
  assign save_details_o = res_q.save_details;
  assign led_update_o   = res_q.led_update;
  assign led_managed_o  = res_q.led_managed;
  assign node_out_o     = res_q.node_out;

endmodule
